### design/hrp_pkg.sv
`default_nettype none

package hrp_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned LEN_W    = 8;
    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned KIND_W   = 8;
    localparam int unsigned OUT_W    = 40;

    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BADSUM   = 3'd1,
        ST_BADSTART = 3'd2,
        ST_NONHEX   = 3'd3,
        ST_SHORT    = 3'd4
    } status_t;

    typedef struct packed {
        logic [KIND_W-1:0] record_kind;
        logic [ADDR_W-1:0] load_address;
        logic [LEN_W-1:0]  byte_count;
        status_t           status;
    } result_t;

endpackage

`default_nettype wire

### design/hrp_in_stage.sv
`default_nettype none

module hrp_in_stage (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,  // in_char
    input  wire logic                        out_space,
    output logic                             advance,
    output logic [hrp_pkg::CHAR_W-1:0]       char_out
);

    logic                        valid_reg;
    logic [hrp_pkg::CHAR_W-1:0]  char_reg;

    assign advance  = valid_reg && out_space;
    assign s_tready = !valid_reg || advance;
    assign char_out = char_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            char_reg <= s_tdata;
        end
    end

endmodule

`default_nettype wire

### design/hrp_core.sv
`default_nettype none

module hrp_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic [hrp_pkg::CHAR_W-1:0]  in_char,
    output logic                             res_valid,
    output hrp_pkg::result_t                 result
);

    typedef enum logic [6:0] {
        PH_IDLE = 7'b0000001,
        PH_LEN  = 7'b0000010,
        PH_ADDR = 7'b0000100,
        PH_TYPE = 7'b0001000,
        PH_DATA = 7'b0010000,
        PH_CSUM = 7'b0100000,
        PH_EOL  = 7'b1000000
    } phase_t;

    phase_t                       phase_reg, phase_next;
    logic [1:0]                   nibble_reg, nibble_next;
    logic [3:0]                   pending_reg, pending_next;
    logic [hrp_pkg::LEN_W-1:0]    left_reg, left_next;
    logic [hrp_pkg::LEN_W-1:0]    length_reg, length_next;
    logic [hrp_pkg::ADDR_W-1:0]   address_reg, address_next;
    logic [hrp_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic [7:0]                   sum_reg, sum_next;

    logic                         eol;
    logic                         is_hex;
    logic [3:0]                   digit;
    logic                         byte_done;
    logic [7:0]                   full_byte;
    logic [hrp_pkg::LEN_W-1:0]    left_dec;
    logic                         hit;

    always_comb
    begin
        is_hex = 1'b1;
        digit  = 4'd0;
        if (in_char >= 8'h30 && in_char <= 8'h39)
        begin
            digit = 4'(in_char - 8'h30);
        end
        else if (in_char >= 8'h41 && in_char <= 8'h46)
        begin
            digit = 4'(in_char - 8'h37);
        end
        else if (in_char >= 8'h61 && in_char <= 8'h66)
        begin
            digit = 4'(in_char - 8'h57);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    assign eol       = (in_char == hrp_pkg::CHAR_LF) || (in_char == hrp_pkg::CHAR_CR);
    assign byte_done = nibble_reg[0];
    assign full_byte = {pending_reg, digit};
    assign left_dec  = left_reg - 8'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        nibble_next  = nibble_reg;
        pending_next = pending_reg;
        left_next    = left_reg;
        length_next  = length_reg;
        address_next = address_reg;
        kind_next    = kind_reg;
        sum_next     = sum_reg;
        hit          = 1'b0;
        result.status        = hrp_pkg::ST_OK;
        result.byte_count    = length_reg;
        result.load_address  = address_reg;
        result.record_kind   = kind_reg;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (eol)
                begin
                    phase_next = PH_IDLE;
                end
                else if (in_char == hrp_pkg::CHAR_COLON)
                begin
                    phase_next   = PH_LEN;
                    nibble_next  = 2'd0;
                    pending_next = 4'd0;
                    left_next    = '0;
                    length_next  = '0;
                    address_next = '0;
                    kind_next    = '0;
                    sum_next     = '0;
                end
                else
                begin
                    phase_next           = PH_EOL;
                    hit                  = 1'b1;
                    result.status        = hrp_pkg::ST_BADSTART;
                    result.byte_count    = '0;
                    result.load_address  = '0;
                    result.record_kind   = '0;
                end
            end
            PH_EOL:
            begin
                if (eol)
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_LEN, PH_ADDR, PH_TYPE, PH_DATA, PH_CSUM:
            begin
                if (eol)
                begin
                    phase_next    = PH_IDLE;
                    hit           = 1'b1;
                    result.status = hrp_pkg::ST_SHORT;
                end
                else if (!is_hex)
                begin
                    phase_next    = PH_EOL;
                    hit           = 1'b1;
                    result.status = hrp_pkg::ST_NONHEX;
                end
                else
                begin
                    if (byte_done)
                    begin
                        sum_next = sum_reg + full_byte;
                    end
                    else
                    begin
                        pending_next = digit;
                    end
                    nibble_next = nibble_reg + 2'd1;

                    unique case (phase_reg)
                        PH_LEN:
                        begin
                            length_next = {length_reg[3:0], digit};
                            if (byte_done)
                            begin
                                phase_next  = PH_ADDR;
                                nibble_next = 2'd0;
                            end
                        end
                        PH_ADDR:
                        begin
                            address_next = {address_reg[11:0], digit};
                            if (nibble_reg == 2'd3)
                            begin
                                phase_next = PH_TYPE;
                            end
                        end
                        PH_TYPE:
                        begin
                            kind_next = {kind_reg[3:0], digit};
                            if (byte_done)
                            begin
                                nibble_next = 2'd0;
                                left_next   = length_reg;
                                phase_next  = (length_reg != '0) ? PH_DATA : PH_CSUM;
                            end
                        end
                        PH_DATA:
                        begin
                            if (byte_done)
                            begin
                                nibble_next = 2'd0;
                                left_next   = left_dec;
                                if (left_dec == '0)
                                begin
                                    phase_next = PH_CSUM;
                                end
                            end
                        end
                        default:
                        begin
                            if (byte_done)
                            begin
                                nibble_next   = 2'd0;
                                phase_next    = PH_EOL;
                                hit           = 1'b1;
                                result.status = (sum_reg + full_byte == 8'd0) ?
                                                hrp_pkg::ST_OK : hrp_pkg::ST_BADSUM;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign res_valid = step && hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            nibble_reg  <= 2'd0;
            pending_reg <= 4'd0;
            left_reg    <= '0;
            length_reg  <= '0;
            address_reg <= '0;
            kind_reg    <= '0;
            sum_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            nibble_reg  <= nibble_next;
            pending_reg <= pending_next;
            left_reg    <= left_next;
            length_reg  <= length_next;
            address_reg <= address_next;
            kind_reg    <= kind_next;
            sum_reg     <= sum_next;
        end
    end

endmodule

`default_nettype wire

### design/hrp_out_stage.sv
`default_nettype none

module hrp_out_stage (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire hrp_pkg::result_t            result,
    output logic                             space,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [hrp_pkg::OUT_W-1:0]        m_tdata
);

    logic               valid_reg;
    hrp_pkg::result_t   data_reg;

    assign space    = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (space)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (space && load)
        begin
            data_reg <= result;
        end
    end

endmodule

`default_nettype wire

### design/hex_record_parser.sv
`default_nettype none

// Intel HEX record parser. Feed one ASCII character per transfer on the slave
// side; one result leaves on the master side for each record line (ok or bad
// checksum on the second checksum digit) and for each faulty line (bad start,
// non-hex digit, or a line end that cuts a record short). Blank lines give
// nothing. A character is taken every cycle while results are drained; a
// character is first held in the input register while the parse state is
// updated, and its result, if any, is then held in the result register until
// its own transfer on the master side.
module hex_record_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // [7:0] in_char
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [39:0]        m_tdata    // [2:0] status, [10:3] byte_count,
                                          // [26:11] load_address, [34:27] record_kind
);

    logic                        out_space;
    logic                        advance;
    logic [hrp_pkg::CHAR_W-1:0]  cur_char;
    logic                        res_valid;
    hrp_pkg::result_t            result;

    hrp_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .out_space (out_space),
        .advance   (advance),
        .char_out  (cur_char)
    );

    hrp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .in_char   (cur_char),
        .res_valid (res_valid),
        .result    (result)
    );

    hrp_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .result   (result),
        .space    (out_space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] <= 3'(hrp_pkg::ST_SHORT)))
        else $error("status code out of range");

    a_badstart_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2:0] == 3'(hrp_pkg::ST_BADSTART)) |->
        (m_tdata[34:3] == 32'd0))
        else $error("bad start result carries fields");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(res_valid))
        else $error("result without a parse step");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[39:35] == 5'd0))
        else $error("padding bits not zero");

    a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tready || !m_tvalid) |-> s_tready)
        else $error("input stalled while output is free");
`endif

endmodule

`default_nettype wire
